// ===== rtl/sobth_pkg.sv =====
// Shared types and constants for the Sobel edge threshold block.
`timescale 1ns / 1ps
package sobth_pkg;

	localparam int PIX_W         = 8;
	localparam int ROW_W         = 16;
	localparam int OUT_COL_W     = 10;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int WIDTH_REG_W   = 11;
	localparam int HEIGHT_REG_W  = 16;
	localparam int THR_W         = 11;
	localparam int THR_SQ_W      = 2 * THR_W;
	localparam int MAG_W         = 22;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;
	localparam int THR_RESET     = 70;
	localparam int MAX_RES       = 3;
	localparam int RES_CNT_W     = $clog2(MAX_RES + 1);

	localparam logic [PIX_W-1:0] EDGE_VAL = 8'd255;
	localparam logic [PIX_W-1:0] FLAT_VAL = 8'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_THRESH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic [PIX_W-1:0]     val;
		logic                 border;
	} res_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0] cnt;
		res_t [MAX_RES-1:0]   ent;
	} res_set_t;

endpackage

// ===== rtl/sobth_line_buf.sv =====
// Two line stores with registered read and same-address write forwarding.
`timescale 1ns / 1ps
module sobth_line_buf import sobth_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	input  logic             wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  logic [PIX_W-1:0] wr_upper,
	input  logic [PIX_W-1:0] wr_middle,
	output logic [PIX_W-1:0] rd_upper,
	output logic [PIX_W-1:0] rd_middle
);

	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0] upper_rd_s1;
	logic [PIX_W-1:0] middle_rd_s1;
	logic [PIX_W-1:0] fwd_upper_s1;
	logic [PIX_W-1:0] fwd_middle_s1;
	logic             fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
		if (rd_en) begin
			upper_rd_s1   <= upper_mem[rd_addr];
			middle_rd_s1  <= middle_mem[rd_addr];
			fwd_upper_s1  <= wr_upper;
			fwd_middle_s1 <= wr_middle;
		end
	end

	// write and read of the same column at one edge: take the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_upper  = fwd_q ? fwd_upper_s1 : upper_rd_s1;
	assign rd_middle = fwd_q ? fwd_middle_s1 : middle_rd_s1;

endmodule

// ===== rtl/sobth_kernel.sv =====
// 3x3 window, Sobel gradient threshold and per-pixel result selection.
`timescale 1ns / 1ps
module sobth_kernel import sobth_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [PIX_W-1:0]    pix,
	input  logic [PIX_W-1:0]    ru,
	input  logic [PIX_W-1:0]    rm,
	input  logic [COL_W-1:0]    col,
	input  logic [ROW_W-1:0]    row,
	input  logic [COL_W:0]      w_eff,
	input  logic [ROW_W-1:0]    h_eff,
	input  logic [THR_SQ_W-1:0] thr_sq,
	output res_set_t            res_set
);

	// left column upper/middle/lower, centre column upper/middle/lower
	logic [PIX_W-1:0] lu_q, lm_q, ll_q, cu_q, cm_q, cl_q;

	logic [PIX_W+1:0]         sum_r, sum_l, sum_b, sum_t;
	logic signed [PIX_W+2:0]  gx, gy;
	logic signed [MAG_W-1:0]  gx2, gy2;
	logic [MAG_W-1:0]         mag2;
	logic [PIX_W-1:0]         mark;
	logic [COL_W:0]           col_inc;
	logic [ROW_W:0]           row_inc;
	logic [ROW_W-1:0]         row_up;
	logic [COL_W-1:0]         col_left;
	logic                     mid_row, has_left, interior, row_end, copy_row;
	logic [RES_CNT_W-1:0]     n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lu_q <= '0;
			lm_q <= '0;
			ll_q <= '0;
			cu_q <= '0;
			cm_q <= '0;
			cl_q <= '0;
		end else if (adv) begin
			lu_q <= cu_q;
			lm_q <= cm_q;
			ll_q <= cl_q;
			cu_q <= ru;
			cm_q <= rm;
			cl_q <= pix;
		end
	end

	always_comb begin
		sum_r = {2'b00, ru} + {1'b0, rm, 1'b0} + {2'b00, pix};
		sum_l = {2'b00, lu_q} + {1'b0, lm_q, 1'b0} + {2'b00, ll_q};
		sum_b = {2'b00, ll_q} + {1'b0, cl_q, 1'b0} + {2'b00, pix};
		sum_t = {2'b00, lu_q} + {1'b0, cu_q, 1'b0} + {2'b00, ru};
		gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
		gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
		gx2   = gx * gx;
		gy2   = gy * gy;
		mag2  = $unsigned(gx2) + $unsigned(gy2);
		mark  = (mag2 > MAG_W'(thr_sq)) ? EDGE_VAL : FLAT_VAL;
	end

	always_comb begin
		col_inc  = {1'b0, col} + 1'b1;
		row_inc  = {1'b0, row} + 1'b1;
		row_up   = row - 1'b1;
		col_left = col - 1'b1;
		mid_row  = row >= ROW_W'(2);
		has_left = col != '0;
		interior = (col >= COL_W'(2)) && (col_inc <= w_eff);
		row_end  = col_inc >= w_eff;
		copy_row = (row == '0) || (row_inc >= {1'b0, h_eff});

		res_set = '0;
		n       = '0;
		if (mid_row && has_left) begin
			res_set.ent[n].row    = row_up;
			res_set.ent[n].col    = OUT_COL_W'(col_left);
			res_set.ent[n].val    = interior ? mark : cm_q;
			res_set.ent[n].border = !interior;
			n = n + 1'b1;
		end
		if (mid_row && row_end) begin
			res_set.ent[n].row    = row_up;
			res_set.ent[n].col    = OUT_COL_W'(col);
			res_set.ent[n].val    = rm;
			res_set.ent[n].border = 1'b1;
			n = n + 1'b1;
		end
		if (copy_row) begin
			res_set.ent[n].row    = row;
			res_set.ent[n].col    = OUT_COL_W'(col);
			res_set.ent[n].val    = pix;
			res_set.ent[n].border = 1'b1;
			n = n + 1'b1;
		end
		res_set.cnt = n;
	end

endmodule

// ===== rtl/sobth_res_buf.sv =====
// Result register: holds the results of one pixel and sends them one per beat.
`timescale 1ns / 1ps
module sobth_res_buf import sobth_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  res_set_t             set_in,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ROW_W-1:0]     out_row,
	output logic [OUT_COL_W-1:0] out_column,
	output logic [PIX_W-1:0]     out_value,
	output logic                 is_border,
	output logic                 last_in_run
);

	res_t [MAX_RES-1:0]   ent_s2;
	logic [RES_CNT_W-1:0] cnt_q;
	logic [RES_CNT_W-1:0] idx_q;
	res_t                 cur;

	always_comb begin
		out_valid   = cnt_q != '0;
		last_in_run = idx_q == RES_CNT_W'(cnt_q - 1'b1);
		free        = !out_valid || (out_ready && last_in_run);
		case (idx_q)
			RES_CNT_W'(0): cur = ent_s2[0];
			RES_CNT_W'(1): cur = ent_s2[1];
			default:       cur = ent_s2[MAX_RES-1];
		endcase
		out_row    = cur.row;
		out_column = cur.col;
		out_value  = cur.val;
		is_border  = cur.border;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_s2 <= set_in.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= set_in.cnt;
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			if (last_in_run) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sobel_edge_threshold_top.sv =====
// Sobel 3x3 edge detector with squared-magnitude threshold, streaming top level.
//
// Input channel (in_valid/in_ready/grey_pixel) takes 8-bit grey pixels in raster
// order, one beat per pixel. Output channel (out_valid/out_ready) sends result
// beats with row, column, value, is_border and last_in_run; a pixel yields zero
// to three beats, last_in_run marks the final one. Interior pixels give 255 or 0,
// border rows and columns are copied. Row 0 and the last row come out as they
// arrive, other rows one row late.
// Path: a pixel is registered in the input stage, then its result beats are loaded
// into the result register once that register is free, which raises out_valid.
// Throughput: one pixel per clock while each pixel yields at most one result and
// out_ready stays high; the result register sends one beat per clock unless
// stalled, so a row end or the last row of a frame taller than two rows slows
// input. A pixel is taken while the previous results wait, through the input stage
// and the result register; a pixel with no results passes a busy result register.
// Receiver stall: the result register holds, the input stage fills, in_ready drops.
// Reset: counters, window and handshakes clear, registers return to 640x480,
// threshold 70. Line stores are not cleared; a frame fills them before use.
// Configuration (cfg_write/cfg_addr/cfg_wdata) must be written only while idle; not enforced.
`timescale 1ns / 1ps
module sobel_edge_threshold_top import sobth_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      grey_pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ROW_W-1:0]      out_row,
	output logic [OUT_COL_W-1:0]  out_column,
	output logic [PIX_W-1:0]      out_value,
	output logic                  is_border,
	output logic                  last_in_run
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [THR_W-1:0]        thr_q;
	logic [THR_SQ_W-1:0]     thr_sq_q;

	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [COL_W:0]          w_eff;
	logic [ROW_W-1:0]        h_eff;

	logic                    v_s1;
	logic [PIX_W-1:0]        pix_s1;
	logic [COL_W-1:0]        col_s1;
	logic [ROW_W-1:0]        row_s1;

	logic                    in_fire, s1_go, buf_free, buf_load;
	logic [PIX_W-1:0]        ru, rm;
	res_set_t                res_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_W'(WIDTH_RESET);
			height_q <= HEIGHT_REG_W'(HEIGHT_RESET);
			thr_q    <= THR_W'(THR_RESET);
		end else if (cfg_write) begin
			case (cfg_addr)
				REG_WIDTH:  width_q  <= cfg_wdata[WIDTH_REG_W-1:0];
				REG_HEIGHT: height_q <= cfg_wdata[HEIGHT_REG_W-1:0];
				REG_THRESH: thr_q    <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q <= THR_SQ_W'(THR_RESET * THR_RESET);
		end else begin
			thr_sq_q <= thr_q * thr_q;
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = (COL_W+1)'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = (COL_W+1)'(MAX_WIDTH);
		end else begin
			w_eff = (COL_W+1)'(width_q);
		end
		h_eff = (height_q == '0) ? ROW_W'(1) : height_q;
	end

	// a pixel with no results moves on without touching the result register
	always_comb begin
		s1_go    = v_s1 && ((res_set.cnt == '0) || buf_free);
		buf_load = s1_go && (res_set.cnt != '0);
		in_ready = !v_s1 || s1_go;
		in_fire  = in_valid && in_ready;
	end

	// raster position of the next input pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (({1'b0, col_q} + 1'b1) >= w_eff) begin
				col_q <= '0;
				row_q <= (({1'b0, row_q} + 1'b1) >= {1'b0, h_eff}) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1 <= grey_pixel;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	sobth_line_buf #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_line_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_fire),
		.rd_addr   (col_q),
		.wr_en     (s1_go),
		.wr_addr   (col_s1),
		.wr_upper  (rm),
		.wr_middle (pix_s1),
		.rd_upper  (ru),
		.rd_middle (rm)
	);

	sobth_kernel #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (s1_go),
		.pix     (pix_s1),
		.ru      (ru),
		.rm      (rm),
		.col     (col_s1),
		.row     (row_s1),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.thr_sq  (thr_sq_q),
		.res_set (res_set)
	);

	sobth_res_buf u_res_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (buf_load),
		.set_in      (res_set),
		.free        (buf_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_row     (out_row),
		.out_column  (out_column),
		.out_value   (out_value),
		.is_border   (is_border),
		.last_in_run (last_in_run)
	);

endmodule

// ===== dv/tb_sobel_edge_threshold_top.sv =====
// Self-checking testbench for sobel_edge_threshold_top: predicts every result beat and compares.
`timescale 1ns / 1ps
module tb_sobel_edge_threshold_top;
	import sobth_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BEATS = 80;
	localparam int MAX_REPORTS  = 10;
	localparam int THR_TOP      = 1443;
	localparam int THR_ALL_ONES = 2047;
	localparam int WIDTH_OVER   = 2047;
	localparam int HEIGHT_TOP   = 65535;

	typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_BLOCKS, PIX_FLAT} pix_mode_t;

	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic [PIX_W-1:0]     val;
		logic                 border;
		logic                 last;
	} edge_result_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_write  = 1'b0;
	cfg_reg_t              cfg_addr   = REG_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      grey_pixel = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [ROW_W-1:0]      out_row;
	logic [OUT_COL_W-1:0]  out_column;
	logic [PIX_W-1:0]      out_value;
	logic                  is_border;
	logic                  last_in_run;

	// predictor state
	logic [PIX_W-1:0] line_upper [DEF_MAX_WIDTH];
	logic [PIX_W-1:0] line_middle [DEF_MAX_WIDTH];
	int               win [6];
	int               row_pos;
	int               col_pos;
	int               width_reg  = WIDTH_RESET;
	int               height_reg = HEIGHT_RESET;
	int               thresh_reg = THR_RESET;
	edge_result_t     pending_results [$];

	int               mismatch_count;
	int               idle_cycles;
	int               total_beats;
	int               hold_req;
	int               hold_left;
	int               stall_left;
	bit               sender_gaps   = 1'b1;
	bit               receiver_gaps = 1'b1;
	logic [PIX_W-1:0] last_pixel    = '0;

	sobel_edge_threshold_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.grey_pixel  (grey_pixel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_row     (out_row),
		.out_column  (out_column),
		.out_value   (out_value),
		.is_border   (is_border),
		.last_in_run (last_in_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic edge_result_t mk_result(int row, int col, int val, bit border);
		edge_result_t e;
		e.row    = row[ROW_W-1:0];
		e.col    = col[OUT_COL_W-1:0];
		e.val    = val[PIX_W-1:0];
		e.border = border;
		e.last   = 1'b0;
		return e;
	endfunction

	// expected result beats of one accepted pixel, then window/line store/counter update
	function automatic void predict_pixel(logic [PIX_W-1:0] pix);
		edge_result_t res [MAX_RES];
		int w, h, c, r, p, ru, rm, gx, gy, n;
		w = width_reg;
		h = height_reg;
		c = col_pos;
		r = row_pos;
		p = int'(pix);
		n = 0;
		if (w < 1) w = 1;
		if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
		if (h < 1) h = 1;
		if (c >= DEF_MAX_WIDTH) c = DEF_MAX_WIDTH - 1;
		ru = int'(line_upper[c]);
		rm = int'(line_middle[c]);
		if (r >= 2) begin
			if (c >= 1) begin
				if (c >= 2 && c + 1 <= w) begin
					gx = (ru + 2 * rm + p) - (win[0] + 2 * win[1] + win[2]);
					gy = (win[2] + 2 * win[5] + p) - (win[0] + 2 * win[3] + ru);
					res[n] = mk_result(r - 1, c - 1,
						(gx * gx + gy * gy > thresh_reg * thresh_reg) ?
						int'(EDGE_VAL) : int'(FLAT_VAL), 1'b0);
				end else begin
					res[n] = mk_result(r - 1, c - 1, win[4], 1'b1);
				end
				n++;
			end
			if (c + 1 >= w) begin
				res[n] = mk_result(r - 1, c, rm, 1'b1);
				n++;
			end
		end
		if (r == 0 || r + 1 >= h) begin
			res[n] = mk_result(r, c, p, 1'b1);
			n++;
		end
		if (n > 0) res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) pending_results.push_back(res[i]);

		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = ru;
		win[4] = rm;
		win[5] = p;
		line_upper[c]  = PIX_W'(rm);
		line_middle[c] = pix;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic void note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
	endfunction

	// predict on input beats, check output beats, watch for a hung handshake
	always @(posedge clk) begin
		edge_result_t got, want;
		if (arst_n) begin
			if (in_valid && in_ready) predict_pixel(grey_pixel);
			if (out_valid && out_ready) begin
				got = {out_row, out_column, out_value, is_border, last_in_run};
				if (pending_results.size() == 0) begin
					note_mismatch($sformatf("unexpected beat row %0d col %0d value %0d",
						got.row, got.col, got.val));
				end else begin
					want = pending_results.pop_front();
					if (got.row !== want.row || got.col !== want.col || got.val !== want.val ||
						got.border !== want.border || got.last !== want.last)
						note_mismatch($sformatf({"expected row %0d col %0d value %0d border %0b ",
							"last %0b, got row %0d col %0d value %0d border %0b last %0b"},
							want.row, want.col, want.val, want.border, want.last,
							got.row, got.col, got.val, got.border, got.last));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("sobel_edge_threshold_top verification failed");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// receiver: long hold-off on request, otherwise random stalls
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (receiver_gaps && $urandom_range(0, 99) < 20) begin
			stall_left = pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic [PIX_W-1:0] gen_pixel(pix_mode_t mode);
		int roll, v;
		roll = $urandom_range(0, 99);
		case (mode)
			PIX_SMOOTH: begin
				v = int'(last_pixel) + int'($urandom_range(0, 16)) - 8;
				if (v < 0) v = 0;
				if (v > 255) v = 255;
			end
			PIX_BLOCKS: begin
				if ((col_pos / 3 + row_pos / 2) % 2 != 0)
					v = 200 + int'($urandom_range(0, 55));
				else
					v = $urandom_range(0, 40);
			end
			PIX_FLAT: begin
				v = int'(last_pixel);
			end
			default: begin
				v = (roll < 15) ? 0 : (roll < 30) ? 255 : $urandom_range(0, 255);
			end
		endcase
		last_pixel = v[PIX_W-1:0];
		return last_pixel;
	endfunction

	task automatic send_pixel(logic [PIX_W-1:0] pix);
		int gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		grey_pixel <= pix;
		do @(posedge clk); while (!in_ready);
		total_beats++;
	endtask

	task automatic send_pixels(int count, pix_mode_t mode);
		for (int i = 0; i < count; i++) send_pixel(gen_pixel(mode));
	endtask

	// drop valid, wait out every expected beat and the pipeline tail
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_WIDTH:  width_reg  = int'(value[WIDTH_REG_W-1:0]);
			REG_HEIGHT: height_reg = int'(value[HEIGHT_REG_W-1:0]);
			default:    thresh_reg = int'(value[THR_W-1:0]);
		endcase
	endtask

	// one whole frame from row 0, column 0
	task automatic send_frame(int w, int h, pix_mode_t mode);
		int cols, rows;
		cols = (w < 1) ? 1 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
		rows = (h < 1) ? 1 : h;
		wait_idle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		send_pixels(cols * rows, mode);
	endtask

	task automatic test_directed_frame();
		logic [PIX_W-1:0] pattern [20] = '{
			8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
			8'd255, 8'd255, 8'd255, 8'd0,   8'd0,
			8'd0,   8'd0,   8'd255, 8'd255, 8'd255,
			8'd128, 8'd1,   8'd254, 8'd127, 8'd0};
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		wait_idle();
		write_reg(REG_WIDTH, 5);
		write_reg(REG_HEIGHT, 4);
		foreach (pattern[i]) send_pixel(pattern[i]);
		wait_idle();
	endtask

	task automatic test_threshold_extremes();
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		wait_idle();
		write_reg(REG_THRESH, 0);
		send_frame(4, 3, PIX_FLAT);
		send_frame(4, 3, PIX_NOISE);
		wait_idle();
		write_reg(REG_THRESH, THR_TOP);
		send_frame(5, 3, PIX_BLOCKS);
		wait_idle();
		write_reg(REG_THRESH, THR_ALL_ONES);
		send_frame(4, 3, PIX_NOISE);
		wait_idle();
		write_reg(REG_THRESH, 1);
		send_frame(4, 4, PIX_SMOOTH);
	endtask

	task automatic test_small_images();
		send_frame(0, 3, PIX_NOISE);
		send_frame(1, 2, PIX_NOISE);
		send_frame(2, 4, PIX_NOISE);
		send_frame(3, 0, PIX_NOISE);
		send_frame(4, 1, PIX_NOISE);
		send_frame(1, 1, PIX_NOISE);
	endtask

	// height and width lowered part way through a frame
	task automatic test_cut_frames();
		wait_idle();
		write_reg(REG_THRESH, 150);
		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, HEIGHT_TOP);
		send_pixels(12, PIX_NOISE);
		wait_idle();
		write_reg(REG_HEIGHT, 1);
		send_pixels(3, PIX_NOISE);
		wait_idle();
		write_reg(REG_WIDTH, 6);
		write_reg(REG_HEIGHT, 3);
		send_pixels(10, PIX_SMOOTH);
		wait_idle();
		write_reg(REG_WIDTH, 3);
		send_pixels(4, PIX_SMOOTH);
	endtask

	// over-range width on a single-row frame, row ended by a lowered width
	task automatic test_wide_rows();
		wait_idle();
		write_reg(REG_WIDTH, WIDTH_OVER);
		write_reg(REG_HEIGHT, 1);
		send_pixels(40, PIX_NOISE);
		wait_idle();
		write_reg(REG_WIDTH, 3);
		send_pixels(1, PIX_NOISE);
	endtask

	task automatic test_backpressure();
		wait_idle();
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		write_reg(REG_THRESH, 120);
		write_reg(REG_WIDTH, 8);
		write_reg(REG_HEIGHT, 6);
		hold_req = 300;
		send_pixels(48, PIX_NOISE);
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		send_pixels(20, PIX_BLOCKS);
		wait_idle();
		send_pixels(28, PIX_BLOCKS);
	endtask

	task automatic test_random_frames();
		int start, w, h, roll;
		start = total_beats;
		while (total_beats - start < RANDOM_BEATS) begin
			roll = $urandom_range(0, 99);
			if (roll < 10)
				w = $urandom_range(0, 2);
			else if (roll < 80)
				w = $urandom_range(3, 12);
			else
				w = $urandom_range(13, 24);
			h = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 2) : $urandom_range(3, 6);
			roll = $urandom_range(0, 99);
			wait_idle();
			if (roll < 10)
				write_reg(REG_THRESH, 0);
			else if (roll < 20)
				write_reg(REG_THRESH, $urandom_range(1000, THR_ALL_ONES));
			else
				write_reg(REG_THRESH, $urandom_range(20, 400));
			sender_gaps   = $urandom_range(0, 3) != 0;
			receiver_gaps = $urandom_range(0, 3) != 0;
			send_frame(w, h, pix_mode_t'($urandom_range(0, 3)));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_frame();
		test_threshold_extremes();
		test_small_images();
		test_cut_frames();
		test_wide_rows();
		test_backpressure();
		test_random_frames();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("sobel_edge_threshold_top verification clean");
		else
			$display("sobel_edge_threshold_top verification failed");
		$finish;
	end

endmodule

// ===== sobel_edge_threshold_top.f =====
rtl/sobth_pkg.sv
rtl/sobth_line_buf.sv
rtl/sobth_kernel.sv
rtl/sobth_res_buf.sv
rtl/sobel_edge_threshold_top.sv
dv/tb_sobel_edge_threshold_top.sv
